### sv/gpp_pkg.sv
`default_nettype none
package gpp_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_PIN   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DRV_RELEASE = 2'd0,
    DRV_LOW     = 2'd1,
    DRV_HIGH    = 2'd2
  } drive_t;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_RO     = 2'd1;
  localparam logic [1:0] STAT_UNIMPL = 2'd2;

  // register map, in 32-bit words
  localparam logic [5:0] OFF_DATA   = 6'h00;
  localparam logic [5:0] OFF_DIR    = 6'h01;
  localparam logic [5:0] OFF_CTRL   = 6'h02;
  localparam logic [5:0] OFF_IEN    = 6'h0c;
  localparam logic [5:0] OFF_IMASK  = 6'h0d;
  localparam logic [5:0] OFF_ITYPE  = 6'h0e;
  localparam logic [5:0] OFF_IPOL   = 6'h0f;
  localparam logic [5:0] OFF_MSTAT  = 6'h10;
  localparam logic [5:0] OFF_RSTAT  = 6'h11;
  localparam logic [5:0] OFF_DEB    = 6'h12;
  localparam logic [5:0] OFF_EOI    = 6'h13;
  localparam logic [5:0] OFF_LEVELS = 6'h14;
  localparam logic [5:0] OFF_SYNC   = 6'h18;
  localparam logic [5:0] OFF_ID     = 6'h19;
  localparam logic [5:0] OFF_VER    = 6'h1b;
  localparam logic [5:0] OFF_PAR2   = 6'h1c;
  localparam logic [5:0] OFF_PAR1   = 6'h1d;

  // identification registers on the configuration port
  localparam logic [1:0] CFG_ID   = 2'd0;
  localparam logic [1:0] CFG_VER  = 2'd1;
  localparam logic [1:0] CFG_PAR1 = 2'd2;
  localparam logic [1:0] CFG_PAR2 = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  word_offset;
    logic [31:0] write_data;
    logic [4:0]  pin_index;
    logic [1:0]  pin_drive;
  } gpp_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic [31:0] pin_levels;
    logic [31:0] drive_conflict;
    logic [1:0]  access_status;
  } gpp_result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] version;
    logic [31:0] par1;
    logic [31:0] par2;
  } gpp_ident_t;

endpackage
`default_nettype wire

### sv/gpio_port_with_interrupts.sv
// GPIO port with level/edge interrupts. Each input transaction is a register
// read, a register write or an external pin drive event; each yields exactly
// one result transaction with read data, irq, resolved pin levels, the drive
// conflict mask and an access status. One transaction is accepted per cycle
// while the input register is free or moving on; it is captured in the input
// register, and the update logic loads the result register from it when the
// result register is free. While a result waits to be taken, one more
// transaction can be accepted into the input register; then the input stalls.
// Identification words are written through the cfg_ APB port.
`default_nettype none
module gpio_port_with_interrupts #(
  parameter int          NUM_PINS       = 32,
  parameter logic [31:0] INIT_DATA      = 32'h0,
  parameter logic [31:0] INIT_DIRECTION = 32'h0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [5:0]  in_word_offset,
  input  wire logic [31:0] in_write_data,
  input  wire logic [4:0]  in_pin_index,
  input  wire logic [1:0]  in_pin_drive,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic             out_irq,
  output logic [31:0]      out_pin_levels,
  output logic [31:0]      out_drive_conflict,
  output logic [1:0]       out_access_status,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import gpp_pkg::*;

  gpp_item_t   item_r;
  logic        item_vld_r, item_vld_nxt;
  gpp_result_t res, res_r;
  logic        out_vld_r, out_vld_nxt;
  logic        advance, take_in;
  gpp_ident_t  ident;

  assign advance      = item_vld_r & (~out_vld_r | out_ready);
  assign in_ready     = ~item_vld_r | advance;
  assign take_in      = in_valid & in_ready;
  assign item_vld_nxt = take_in | (item_vld_r & ~advance);
  assign out_vld_nxt  = advance | (out_vld_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      item_r <= '{kind: in_kind, word_offset: in_word_offset, write_data: in_write_data,
                  pin_index: in_pin_index, pin_drive: in_pin_drive};
    end
    if (advance) begin
      res_r <= res;
    end
  end

  gpp_core #(
    .NUM_PINS       (NUM_PINS),
    .INIT_DATA      (INIT_DATA),
    .INIT_DIRECTION (INIT_DIRECTION)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .ident (ident),
    .res   (res)
  );

  gpp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .ident   (ident)
  );

  assign cfg_pready         = 1'b1;
  assign out_valid          = out_vld_r;
  assign out_read_data      = res_r.read_data;
  assign out_irq            = res_r.irq;
  assign out_pin_levels     = res_r.pin_levels;
  assign out_drive_conflict = res_r.drive_conflict;
  assign out_access_status  = res_r.access_status;

endmodule
`default_nettype wire

### sv/gpp_regs.sv
`default_nettype none
module gpp_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output gpp_pkg::gpp_ident_t ident
);
  import gpp_pkg::*;

  gpp_ident_t ident_r;
  logic       wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        CFG_ID:   ident_r.id      <= pwdata;
        CFG_VER:  ident_r.version <= pwdata;
        CFG_PAR1: ident_r.par1    <= pwdata;
        CFG_PAR2: ident_r.par2    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_ID:   prdata = ident_r.id;
      CFG_VER:  prdata = ident_r.version;
      CFG_PAR1: prdata = ident_r.par1;
      CFG_PAR2: prdata = ident_r.par2;
      default:  prdata = '0;
    endcase
  end

  assign ident = ident_r;

endmodule
`default_nettype wire

### sv/gpp_core.sv
`default_nettype none
module gpp_core #(
  parameter int          NUM_PINS       = 32,
  parameter logic [31:0] INIT_DATA      = 32'h0,
  parameter logic [31:0] INIT_DIRECTION = 32'h0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire gpp_pkg::gpp_item_t   item,
  input  wire gpp_pkg::gpp_ident_t  ident,
  output gpp_pkg::gpp_result_t      res
);
  import gpp_pkg::*;

  localparam logic [31:0] PinMask = 32'((64'd1 << NUM_PINS) - 64'd1);

  logic [31:0] data_r, dir_r, ctrl_r, ien_r, imask_r, itype_r, ipol_r;
  logic [31:0] edge_r, deb_r, ext_lvl_r, ext_drv_r, lvl_r;
  logic        sync_r;
  logic [31:0] data_nxt, dir_nxt, ctrl_nxt, ien_nxt, imask_nxt, itype_nxt, ipol_nxt;
  logic [31:0] edge_nxt, deb_nxt, ext_lvl_nxt, ext_drv_nxt, lvl_nxt;
  logic        sync_nxt;

  logic [31:0] raw_cur, raw_nxt, wmask, pin_bit, own_lvl, new_lvl, changed;
  logic [31:0] own_nxt;
  logic [31:0] rdata;
  logic [1:0]  status;
  logic        resolve;

  assign raw_cur = ((edge_r & itype_r) | (~(lvl_r ^ ipol_r) & ~itype_r)) & ien_r & PinMask;
  assign wmask   = item.write_data & PinMask;
  assign pin_bit = 32'd1 << item.pin_index;

  always_comb begin
    data_nxt    = data_r;
    dir_nxt     = dir_r;
    ctrl_nxt    = ctrl_r;
    ien_nxt     = ien_r;
    imask_nxt   = imask_r;
    itype_nxt   = itype_r;
    ipol_nxt    = ipol_r;
    edge_nxt    = edge_r;
    deb_nxt     = deb_r;
    ext_lvl_nxt = ext_lvl_r;
    ext_drv_nxt = ext_drv_r;
    sync_nxt    = sync_r;
    lvl_nxt     = lvl_r;
    rdata       = '0;
    status      = STAT_OK;
    resolve     = 1'b0;
    own_lvl     = '0;
    new_lvl     = '0;
    changed     = '0;

    unique case (item.kind)
      KIND_READ: begin
        unique case (item.word_offset)
          OFF_DATA:   rdata = data_r;
          OFF_DIR:    rdata = dir_r;
          OFF_CTRL:   rdata = ctrl_r;
          OFF_IEN:    rdata = ien_r;
          OFF_IMASK:  rdata = imask_r;
          OFF_ITYPE:  rdata = itype_r;
          OFF_IPOL:   rdata = ipol_r;
          OFF_MSTAT:  rdata = raw_cur & ~imask_r;
          OFF_RSTAT:  rdata = raw_cur;
          OFF_DEB:    rdata = deb_r;
          OFF_EOI:    rdata = '0;
          OFF_LEVELS: rdata = lvl_r;
          OFF_SYNC:   rdata = {31'd0, sync_r};
          OFF_ID:     rdata = ident.id;
          OFF_VER:    rdata = ident.version;
          OFF_PAR2:   rdata = ident.par2;
          OFF_PAR1:   rdata = ident.par1;
          default:    status = STAT_UNIMPL;
        endcase
      end
      KIND_WRITE: begin
        unique case (item.word_offset)
          OFF_DATA: begin
            data_nxt = wmask;
            resolve  = 1'b1;
          end
          OFF_DIR: begin
            dir_nxt = wmask;
            resolve = 1'b1;
          end
          OFF_CTRL:  ctrl_nxt = wmask;
          OFF_IEN:   ien_nxt = wmask;
          OFF_IMASK: imask_nxt = wmask;
          OFF_ITYPE: begin
            itype_nxt = wmask;
            edge_nxt  = edge_r & wmask;
          end
          OFF_IPOL:  ipol_nxt = wmask;
          OFF_DEB:   deb_nxt = wmask;
          OFF_EOI:   edge_nxt = edge_r & ~wmask;
          OFF_SYNC:  sync_nxt = item.write_data[0];
          OFF_MSTAT, OFF_RSTAT, OFF_LEVELS, OFF_ID, OFF_VER, OFF_PAR2, OFF_PAR1:
            status = STAT_RO;
          default:   status = STAT_UNIMPL;
        endcase
      end
      KIND_PIN: begin
        // events on pins beyond the port are dropped silently
        if ({1'b0, item.pin_index} < 6'(NUM_PINS)) begin
          resolve = 1'b1;
          case (item.pin_drive)
            DRV_RELEASE: ext_drv_nxt = ext_drv_r & ~pin_bit;
            DRV_LOW: begin
              ext_drv_nxt = ext_drv_r | pin_bit;
              ext_lvl_nxt = ext_lvl_r & ~pin_bit;
            end
            default: begin
              ext_drv_nxt = ext_drv_r | pin_bit;
              ext_lvl_nxt = ext_lvl_r | pin_bit;
            end
          endcase
        end
      end
      default: status = STAT_UNIMPL;
    endcase

    if (resolve) begin
      own_lvl  = data_nxt & dir_nxt & PinMask;
      new_lvl  = ((ext_lvl_nxt & ext_drv_nxt) | (own_lvl & ~ext_drv_nxt)) & PinMask;
      changed  = lvl_r ^ new_lvl;
      lvl_nxt  = new_lvl;
      edge_nxt = (edge_nxt | (changed & ((new_lvl & ipol_nxt) | (~new_lvl & ~ipol_nxt))
                  & itype_nxt)) & PinMask;
    end
  end

  assign raw_nxt = ((edge_nxt & itype_nxt) | (~(lvl_nxt ^ ipol_nxt) & ~itype_nxt))
                   & ien_nxt & PinMask;
  assign own_nxt = dir_nxt & PinMask;

  assign res.read_data      = rdata;
  assign res.irq            = |(raw_nxt & ~imask_nxt);
  assign res.pin_levels     = lvl_nxt;
  assign res.drive_conflict = own_nxt & ext_drv_nxt & ((data_nxt & own_nxt) ^ ext_lvl_nxt);
  assign res.access_status  = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r    <= INIT_DATA & PinMask;
      dir_r     <= INIT_DIRECTION & PinMask;
      ctrl_r    <= '0;
      ien_r     <= '0;
      imask_r   <= '0;
      itype_r   <= '0;
      ipol_r    <= '0;
      edge_r    <= '0;
      deb_r     <= '0;
      ext_lvl_r <= '0;
      ext_drv_r <= '0;
      sync_r    <= 1'b0;
      lvl_r     <= INIT_DATA & INIT_DIRECTION & PinMask;
    end else if (step) begin
      data_r    <= data_nxt;
      dir_r     <= dir_nxt;
      ctrl_r    <= ctrl_nxt;
      ien_r     <= ien_nxt;
      imask_r   <= imask_nxt;
      itype_r   <= itype_nxt;
      ipol_r    <= ipol_nxt;
      edge_r    <= edge_nxt;
      deb_r     <= deb_nxt;
      ext_lvl_r <= ext_lvl_nxt;
      ext_drv_r <= ext_drv_nxt;
      sync_r    <= sync_nxt;
      lvl_r     <= lvl_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/gpp_checker.sv
`default_nettype none
module gpp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_read_data,
  input wire logic [1:0]  out_access_status
);
  import gpp_pkg::*;

  // status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_access_status == STAT_OK || out_access_status == STAT_RO ||
                   out_access_status == STAT_UNIMPL))
    else $error("undefined access status");

  // failed accesses return no data
  a_unimpl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_access_status != STAT_OK) |-> (out_read_data == 32'd0))
    else $error("nonzero read data on failed access");

  // a result only appears after an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid)) |-> $past(in_valid && in_ready, 2))
    else $error("result without accepted transaction");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_read_data)))
    else $error("stalled result changed");

endmodule

bind gpio_port_with_interrupts gpp_checker u_gpp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_read_data     (out_read_data),
  .out_access_status (out_access_status)
);
`default_nettype wire

### tb/sv/tb_gpio_port_with_interrupts.sv
`timescale 1ns / 100ps
module tb_gpio_port_with_interrupts;
  import gpp_pkg::*;

  localparam logic [1:0] KIND_BAD      = 2'd3;  // unused kind code
  localparam logic [1:0] DRV_HIGH_ALT  = 2'd3;  // also drives high
  localparam logic [5:0] OFF_HOLE      = 6'h1a;  // gap in the ident block
  localparam logic [5:0] OFF_TOP       = 6'h3f;
  localparam int         HOLD_CYCLES   = 64;
  localparam int         CYCLE_LIMIT   = 300000;
  localparam int         SHOW_MAX      = 10;

  typedef struct {
    gpp_item_t   item;
    bit          known;
    gpp_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_READ;
  logic [5:0]  in_word_offset = '0;
  logic [31:0] in_write_data = '0;
  logic [4:0]  in_pin_index = '0;
  logic [1:0]  in_pin_drive = DRV_RELEASE;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;
  logic        out_irq;
  logic [31:0] out_pin_levels;
  logic [31:0] out_drive_conflict;
  logic [1:0]  out_access_status;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // typed-in expectation travels with the item it belongs to
  logic        in_known = 1'b0;
  gpp_result_t in_known_res = '0;

  gpio_port_with_interrupts uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_word_offset(in_word_offset),
    .in_write_data(in_write_data), .in_pin_index(in_pin_index),
    .in_pin_drive(in_pin_drive),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data), .out_irq(out_irq),
    .out_pin_levels(out_pin_levels), .out_drive_conflict(out_drive_conflict),
    .out_access_status(out_access_status),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // GPIO register shadow
  logic [31:0] g_data = '0, g_dir = '0, g_ctrl = '0, g_ien = '0, g_imask = '0;
  logic [31:0] g_itype = '0, g_ipol = '0, g_edges = '0, g_deb = '0;
  logic        g_sync = 1'b0;
  logic [31:0] g_ext_lvl = '0, g_ext_drv = '0, g_levels = '0;
  logic [31:0] ident_word [4] = '{default: '0};

  gpp_result_t pending_responses[$];
  int          mismatch_cnt = 0;
  int          result_cnt = 0;
  int          cycle_cnt = 0;
  int          rx_stall_pct = 0;
  int          tx_idle_pct = 0;
  int          hold_reqs = 0;

  function automatic void settle_pins(input bit track_edges);
    logic [31:0] prev, chg;
    prev = g_levels;
    g_levels = (g_ext_lvl & g_ext_drv) | (g_data & g_dir & ~g_ext_drv);
    chg = prev ^ g_levels;
    if (track_edges)
      g_edges |= ((chg & g_levels & g_ipol) | (chg & ~g_levels & ~g_ipol)) & g_itype;
  endfunction

  function automatic logic [31:0] irq_raw();
    return ((g_edges & g_itype) | (~(g_levels ^ g_ipol) & ~g_itype)) & g_ien;
  endfunction

  function automatic gpp_result_t gpio_response(input gpp_item_t it);
    gpp_result_t r;
    logic [31:0] wd, pbit;
    r = '0;
    r.access_status = STAT_OK;
    wd = it.write_data;
    case (it.kind)
      KIND_READ: begin
        case (it.word_offset)
          OFF_DATA:   r.read_data = g_data;
          OFF_DIR:    r.read_data = g_dir;
          OFF_CTRL:   r.read_data = g_ctrl;
          OFF_IEN:    r.read_data = g_ien;
          OFF_IMASK:  r.read_data = g_imask;
          OFF_ITYPE:  r.read_data = g_itype;
          OFF_IPOL:   r.read_data = g_ipol;
          OFF_MSTAT:  r.read_data = irq_raw() & ~g_imask;
          OFF_RSTAT:  r.read_data = irq_raw();
          OFF_DEB:    r.read_data = g_deb;
          OFF_EOI:    r.read_data = '0;
          OFF_LEVELS: r.read_data = g_levels;
          OFF_SYNC:   r.read_data = {31'b0, g_sync};
          OFF_ID:     r.read_data = ident_word[CFG_ID];
          OFF_VER:    r.read_data = ident_word[CFG_VER];
          OFF_PAR2:   r.read_data = ident_word[CFG_PAR2];
          OFF_PAR1:   r.read_data = ident_word[CFG_PAR1];
          default:    r.access_status = STAT_UNIMPL;
        endcase
      end
      KIND_WRITE: begin
        case (it.word_offset)
          OFF_DATA: begin
            g_data = wd;
            settle_pins(1'b1);
          end
          OFF_DIR: begin
            g_dir = wd;
            settle_pins(1'b1);
          end
          OFF_CTRL:  g_ctrl = wd;
          OFF_IEN:   g_ien = wd;
          OFF_IMASK: g_imask = wd;
          OFF_ITYPE: begin
            g_itype = wd;
            g_edges &= wd;
          end
          OFF_IPOL:  g_ipol = wd;
          OFF_DEB:   g_deb = wd;
          OFF_EOI:   g_edges &= ~wd;
          OFF_SYNC:  g_sync = wd[0];
          OFF_MSTAT, OFF_RSTAT, OFF_LEVELS, OFF_ID, OFF_VER, OFF_PAR2, OFF_PAR1:
            r.access_status = STAT_RO;
          default: r.access_status = STAT_UNIMPL;
        endcase
      end
      KIND_PIN: begin
        pbit = 32'd1 << it.pin_index;
        if (it.pin_drive == DRV_RELEASE) begin
          g_ext_drv &= ~pbit;
        end else begin
          g_ext_drv |= pbit;
          if (it.pin_drive == DRV_LOW) g_ext_lvl &= ~pbit;
          else g_ext_lvl |= pbit;
        end
        settle_pins(1'b1);
      end
      default: r.access_status = STAT_UNIMPL;
    endcase
    r.irq = |(irq_raw() & ~g_imask);
    r.pin_levels = g_levels;
    r.drive_conflict = g_dir & g_ext_drv & ((g_data & g_dir) ^ g_ext_lvl);
    return r;
  endfunction

  // predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    gpp_result_t want, got, pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_read_data, out_irq, out_pin_levels, out_drive_conflict,
                out_access_status};
        result_cnt++;
        if (pending_responses.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOW_MAX)
            $display("result %0d arrived with nothing outstanding: %h", result_cnt, got);
        end else begin
          want = pending_responses.pop_front();
          if (got.read_data !== want.read_data || got.irq !== want.irq ||
              got.pin_levels !== want.pin_levels ||
              got.drive_conflict !== want.drive_conflict ||
              got.access_status !== want.access_status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOW_MAX)
              $display({"result %0d: exp rd=%h irq=%b lvl=%h cfl=%h st=%0d",
                        " | got rd=%h irq=%b lvl=%h cfl=%h st=%0d"}, result_cnt,
                       want.read_data, want.irq, want.pin_levels, want.drive_conflict,
                       want.access_status, got.read_data, got.irq, got.pin_levels,
                       got.drive_conflict, got.access_status);
          end
        end
      end
      if (in_valid && in_ready) begin
        pred = gpio_response('{in_kind, in_word_offset, in_write_data, in_pin_index,
                               in_pin_drive});
        pending_responses.push_back(in_known ? in_known_res : pred);
      end
    end
  end

  // result side backpressure; a long hold-off runs when requested
  initial begin
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input gpp_item_t it, input bit known, input gpp_result_t res);
    in_valid       <= 1'b1;
    in_kind        <= it.kind;
    in_word_offset <= it.word_offset;
    in_write_data  <= it.write_data;
    in_pin_index   <= it.pin_index;
    in_pin_drive   <= it.pin_drive;
    in_known       <= known;
    in_known_res   <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  // always waits on the clock before checking, so the last prediction is queued
  task automatic wait_drained();
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  // setup, access, then an idle spell before the next transfer
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    ident_word[idx] = val;
    @(posedge clk);
  endtask

  task automatic cfg_write_all(input logic [31:0] v0, input logic [31:0] v1,
                               input logic [31:0] v2, input logic [31:0] v3);
    cfg_write(CFG_ID, v0);
    cfg_write(CFG_VER, v1);
    cfg_write(CFG_PAR1, v2);
    cfg_write(CFG_PAR2, v3);
    @(posedge clk);
  endtask

  function automatic logic [5:0] pick_offset();
    case ($urandom_range(16))
      0:  return OFF_DATA;
      1:  return OFF_DIR;
      2:  return OFF_CTRL;
      3:  return OFF_IEN;
      4:  return OFF_IMASK;
      5:  return OFF_ITYPE;
      6:  return OFF_IPOL;
      7:  return OFF_MSTAT;
      8:  return OFF_RSTAT;
      9:  return OFF_DEB;
      10: return OFF_EOI;
      11: return OFF_LEVELS;
      12: return OFF_SYNC;
      13: return OFF_ID;
      14: return OFF_VER;
      15: return OFF_PAR2;
      default: return OFF_PAR1;
    endcase
  endfunction

  function automatic gpp_item_t random_item();
    gpp_item_t it;
    int sel;
    sel = $urandom_range(99);
    if (sel < 34) it.kind = KIND_READ;
    else if (sel < 66) it.kind = KIND_WRITE;
    else if (sel < 96) it.kind = KIND_PIN;
    else it.kind = KIND_BAD;
    it.word_offset = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : pick_offset();
    case ($urandom_range(7))
      0:       it.write_data = '0;
      1:       it.write_data = '1;
      default: it.write_data = $urandom();
    endcase
    it.pin_index = 5'($urandom_range(31));
    it.pin_drive = 2'($urandom_range(3));
    return it;
  endfunction

  task automatic run_phase(input int n, input int rx_pct, input int tx_pct,
                           input int hold_at, input int pause_at);
    rx_stall_pct = rx_pct;
    tx_idle_pct  = tx_pct;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_reqs++;
      if (i == pause_at) begin
        in_valid <= 1'b0;
        wait_drained();
      end else if (i > 0 && $urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
      end
      send_item(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  function automatic stim_row_t row(input logic [1:0] kind, input logic [5:0] off,
                                    input logic [31:0] wd, input logic [4:0] pin,
                                    input logic [1:0] drv);
    stim_row_t s;
    s.item  = '{kind, off, wd, pin, drv};
    s.known = 1'b0;
    s.res   = '0;
    return s;
  endfunction

  // quiet result straight after reset: only read data and status differ
  function automatic stim_row_t known_row(input stim_row_t s, input logic [31:0] rd,
                                          input logic [1:0] st);
    s.known = 1'b1;
    s.res = '{rd, 1'b0, 32'h0, 32'h0, st};
    return s;
  endfunction

  initial begin
    stim_row_t rows[$];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(known_row(row(KIND_READ, OFF_DATA, '0, '0, DRV_RELEASE), '0, STAT_OK));
    rows.push_back(known_row(row(KIND_READ, OFF_ID, '0, '0, DRV_RELEASE), '0, STAT_OK));
    rows.push_back(known_row(row(KIND_READ, OFF_EOI, '0, '0, DRV_RELEASE), '0, STAT_OK));
    rows.push_back(known_row(row(KIND_WRITE, OFF_MSTAT, '1, '0, DRV_RELEASE), '0, STAT_RO));
    rows.push_back(known_row(row(KIND_WRITE, OFF_PAR1, '1, '0, DRV_RELEASE), '0, STAT_RO));
    rows.push_back(known_row(row(KIND_READ, OFF_TOP, '0, '0, DRV_RELEASE), '0, STAT_UNIMPL));
    rows.push_back(known_row(row(KIND_WRITE, OFF_HOLE, '1, '1, DRV_RELEASE), '0,
                             STAT_UNIMPL));
    rows.push_back(known_row(row(KIND_BAD, OFF_DATA, '1, '1, DRV_HIGH), '0, STAT_UNIMPL));
    rows.push_back(row(KIND_WRITE, OFF_DIR, '1, '0, DRV_RELEASE));
    rows.push_back(row(KIND_WRITE, OFF_DATA, 32'ha5a5_a5a5, '0, DRV_RELEASE));
    rows.push_back(row(KIND_WRITE, OFF_ITYPE, 32'h0000_ffff, '0, DRV_RELEASE));
    rows.push_back(row(KIND_WRITE, OFF_IPOL, 32'h00ff_00ff, '0, DRV_RELEASE));
    rows.push_back(row(KIND_WRITE, OFF_IEN, '1, '0, DRV_RELEASE));
    rows.push_back(row(KIND_PIN, '0, '0, 5'd0, DRV_HIGH));
    rows.push_back(row(KIND_PIN, '0, '0, 5'd1, DRV_HIGH));
    rows.push_back(row(KIND_PIN, '0, '0, 5'd31, DRV_HIGH_ALT));
    rows.push_back(row(KIND_PIN, '0, '0, 5'd30, DRV_LOW));
    rows.push_back(row(KIND_READ, OFF_RSTAT, '0, '0, DRV_RELEASE));
    rows.push_back(row(KIND_WRITE, OFF_IMASK, 32'hf0f0_f0f0, '0, DRV_RELEASE));
    rows.push_back(row(KIND_READ, OFF_MSTAT, '0, '0, DRV_RELEASE));
    rows.push_back(row(KIND_PIN, '0, '0, 5'd1, DRV_RELEASE));
    rows.push_back(row(KIND_WRITE, OFF_EOI, '1, '0, DRV_RELEASE));
    rows.push_back(row(KIND_WRITE, OFF_SYNC, '1, '0, DRV_RELEASE));
    rows.push_back(row(KIND_READ, OFF_SYNC, '0, '0, DRV_RELEASE));
    rows.push_back(row(KIND_READ, OFF_LEVELS, '0, '0, DRV_RELEASE));

    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].res);
    in_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);

    // identification extremes, no idling, long output hold-off and a sender pause
    cfg_write_all('1, '1, '1, '1);
    run_phase(250, 0, 0, 60, 160);
    cfg_write_all($urandom(), $urandom(), $urandom(), $urandom());
    run_phase(150, 0, 72, -1, -1);
    cfg_write_all('0, '0, '0, '0);
    run_phase(150, 72, 0, -1, -1);
    cfg_write_all($urandom(), $urandom(), $urandom(), $urandom());
    run_phase(200, 24, 24, 40, 120);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
